@@ rtl/core/ole_pkg.sv @@
// ordered list engine package: action and status codes, widths, cell control type
// no dependencies
`timescale 1ns / 1ps

package ole_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int DATA_W = 32;
  localparam int ACTION_W = 4;
  localparam int POS_W = 5;
  localparam int STATUS_W = 2;
  localparam int LENGTH_W = 5;
  localparam int IN_W = 48;
  localparam int OUT_W = 40;

  localparam logic [ACTION_W-1:0] ACT_INS_FIRST = 4'd0;
  localparam logic [ACTION_W-1:0] ACT_INS_LAST = 4'd1;
  localparam logic [ACTION_W-1:0] ACT_INS_AT = 4'd2;
  localparam logic [ACTION_W-1:0] ACT_DEL_FIRST = 4'd3;
  localparam logic [ACTION_W-1:0] ACT_DEL_LAST = 4'd4;
  localparam logic [ACTION_W-1:0] ACT_DEL_AT = 4'd5;
  localparam logic [ACTION_W-1:0] ACT_RETRIEVE = 4'd6;
  localparam logic [ACTION_W-1:0] ACT_LOCATE = 4'd7;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 4'd8;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

  localparam logic [DATA_W-1:0] NONE_ANSWER = '1;

  typedef struct packed {
    logic load;
    logic take_left;
    logic take_right;
  } cell_ctl_t;

endpackage

@@ rtl/core/ordered_list_engine.sv @@
// ordered list engine top: request decode, chain of list cells, result register
// depends on ole_pkg and ole_cell
//
// Usage:
//   s_axis carries one request per item: action, value and position.
//   m_axis returns exactly one result per request: status, found, answer
//   and the list length after the request.
//   Each request is decoded and carried out in the accept cycle: every cell
//   loads, shifts from a neighbor or holds in parallel, and all cells
//   compare their entry to the value at once for a locate.
//   m_axis_tvalid rises in the cycle after accept. Throughput is one
//   item per cycle while m_axis_tready stays high, as the cell chain shifts
//   and the first-match scan runs across its compare outputs in the accept cycle.
//   When the receiver stalls, the result waits in the output register and
//   s_axis_tready drops until it is taken; taking it frees the register in
//   the same cycle a new request is accepted.
//   Reset empties the list and the output register; stored entries are not
//   cleared, so no clearing pass is needed.
`timescale 1ns / 1ps

module ordered_list_engine #(
  parameter int CAPACITY = ole_pkg::DEF_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // action[3:0], value[35:4], position[40:36], zero fill
  input  logic [ole_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // status[1:0], found[2], answer[34:3], length[39:35]
  output logic [ole_pkg::OUT_W-1:0]   m_axis_tdata
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > ole_pkg::POS_W) ? CNT_W : ole_pkg::POS_W;

  logic [ole_pkg::ACTION_W-1:0] action;
  logic [ole_pkg::DATA_W-1:0]   value;
  logic [ole_pkg::POS_W-1:0]    position;
  logic [CMP_W-1:0]             pos_ext;
  logic [CMP_W-1:0]             cnt_ext;

  logic [CNT_W-1:0]             cnt;
  logic [CNT_W-1:0]             cnt_next;
  logic                         accept;
  logic                         full;
  logic                         empty;

  logic                         ins_ok;
  logic                         del_ok;
  logic                         del_shift;
  logic [CMP_W-1:0]             op_pos;
  logic [ole_pkg::STATUS_W-1:0] status_next;
  logic                         found_next;
  logic [ole_pkg::DATA_W-1:0]   answer_next;

  logic [ole_pkg::DATA_W-1:0]   cell_data [CAPACITY];
  logic [CAPACITY-1:0]          cell_match;
  ole_pkg::cell_ctl_t           cell_ctl  [CAPACITY];
  logic                         hit;
  logic [IDX_W-1:0]             hit_idx;

  logic [ole_pkg::STATUS_W-1:0] status;
  logic                         found;
  logic [ole_pkg::DATA_W-1:0]   answer;
  logic [ole_pkg::LENGTH_W-1:0] length;

  assign action   = s_axis_tdata[3:0];
  assign value    = s_axis_tdata[35:4];
  assign position = s_axis_tdata[40:36];
  assign pos_ext  = CMP_W'(position);
  assign cnt_ext  = CMP_W'(cnt);

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign full   = (cnt == CNT_W'(CAPACITY));
  assign empty  = (cnt == '0);

  // first matching cell among the valid entries
  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (cell_match[i] && (CNT_W'(i) < cnt)) begin
        hit = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    ins_ok = 1'b0;
    del_ok = 1'b0;
    del_shift = 1'b0;
    op_pos = '0;
    status_next = ole_pkg::ST_OK;
    found_next = 1'b0;
    answer_next = ole_pkg::NONE_ANSWER;
    cnt_next = cnt;
    unique case (action)
      ole_pkg::ACT_INS_FIRST, ole_pkg::ACT_INS_LAST, ole_pkg::ACT_INS_AT: begin
        if (full) begin
          status_next = ole_pkg::ST_FULL;
        end else if (action == ole_pkg::ACT_INS_AT && pos_ext > cnt_ext) begin
          status_next = ole_pkg::ST_RANGE;
        end else begin
          ins_ok = 1'b1;
          cnt_next = cnt + 1'b1;
          if (action == ole_pkg::ACT_INS_LAST) begin
            op_pos = cnt_ext;
          end else if (action == ole_pkg::ACT_INS_AT) begin
            op_pos = pos_ext;
          end
        end
      end
      ole_pkg::ACT_DEL_FIRST, ole_pkg::ACT_DEL_LAST, ole_pkg::ACT_DEL_AT: begin
        if (empty) begin
          status_next = ole_pkg::ST_EMPTY;
        end else if (action == ole_pkg::ACT_DEL_AT && pos_ext >= cnt_ext) begin
          status_next = ole_pkg::ST_RANGE;
        end else begin
          del_ok = 1'b1;
          del_shift = (action != ole_pkg::ACT_DEL_LAST);
          cnt_next = cnt - 1'b1;
          if (action == ole_pkg::ACT_DEL_AT) begin
            op_pos = pos_ext;
          end
        end
      end
      ole_pkg::ACT_RETRIEVE: begin
        if (empty) begin
          status_next = ole_pkg::ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status_next = ole_pkg::ST_RANGE;
        end else begin
          found_next = 1'b1;
          answer_next = cell_data[pos_ext[IDX_W-1:0]];
        end
      end
      ole_pkg::ACT_LOCATE: begin
        if (hit) begin
          found_next = 1'b1;
          answer_next = ole_pkg::DATA_W'(hit_idx);
        end
      end
      ole_pkg::ACT_CLEAR: begin
        cnt_next = '0;
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int LEFT = (g == 0) ? 0 : g - 1;
    localparam int RIGHT = (g == CAPACITY - 1) ? g : g + 1;

    always_comb begin
      cell_ctl[g].load = accept && ins_ok && (op_pos == CMP_W'(g));
      cell_ctl[g].take_left = accept && ins_ok && (g != 0) && (op_pos < CMP_W'(g));
      cell_ctl[g].take_right = accept && del_ok && del_shift && (op_pos <= CMP_W'(g));
    end

    ole_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[g]),
      .load_data  (value),
      .left_data  (cell_data[LEFT]),
      .right_data (cell_data[RIGHT]),
      .key        (value),
      .data       (cell_data[g]),
      .match      (cell_match[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        cnt <= cnt_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      found <= found_next;
      answer <= answer_next;
      length <= ole_pkg::LENGTH_W'(cnt_next);
    end
  end

  assign m_axis_tdata = {length, answer, found, status};

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("list count beyond capacity");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && found |-> status == ole_pkg::ST_OK)
    else $error("found flagged with bad status");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid)
    else $error("accepted item gave no result");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && action == ole_pkg::ACT_CLEAR |=> cnt == '0)
    else $error("clear left entries");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    accept && full && (action == ole_pkg::ACT_INS_FIRST || action == ole_pkg::ACT_INS_LAST
      || action == ole_pkg::ACT_INS_AT) |=> cnt == $past(cnt))
    else $error("insert into full list changed count");
`endif

endmodule

@@ rtl/core/ole_cell.sv @@
// one list slot: holds an entry, loads, shifts from a neighbor, compares to the key
// depends on ole_pkg
`timescale 1ns / 1ps

module ole_cell (
  input  logic                         clk,
  input  ole_pkg::cell_ctl_t           ctl,
  input  logic [ole_pkg::DATA_W-1:0]   load_data,
  input  logic [ole_pkg::DATA_W-1:0]   left_data,
  input  logic [ole_pkg::DATA_W-1:0]   right_data,
  input  logic [ole_pkg::DATA_W-1:0]   key,
  output logic [ole_pkg::DATA_W-1:0]   data,
  output logic                         match
);

  always_ff @(posedge clk) begin
    priority if (ctl.load) begin
      data <= load_data;
    end else if (ctl.take_left) begin
      data <= left_data;
    end else if (ctl.take_right) begin
      data <= right_data;
    end else begin
      data <= data;
    end
  end

  assign match = (data == key);

endmodule
